@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds, then cons holds in the next cycle; off while in reset
`define MBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbs assertion failed");

// ante and cons hold in the same cycle; off while in reset
`define MBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mbs assertion failed");

// ante holds, then cons holds in the next cycle; always on
`define MBS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mbs assertion failed");

`endif

@@ rtl/mbs_pkg.sv @@
// Shared constants, types and helper functions of the bitrate selector.
package mbs_pkg;

  localparam int MAX_REPS   = 8;
  localparam int HORIZON    = 5;
  localparam int HIST_DEPTH = 5;

  localparam int REP_W   = 3;
  localparam int CNT_W   = 3;
  localparam int STEP_W  = 3;
  localparam int DT_W    = 48;
  localparam int SUM_W   = 51;
  localparam int ACC_W   = 50;
  localparam int BSUM_W  = 19;
  localparam int REBUF_W = 40;

  localparam logic [REBUF_W-1:0] REBUF_CAP = '1;
  localparam logic signed [63:0] BEST_INIT = -64'sd25600000000000000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_REP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BR_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BR_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_DUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REBUF_WGT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WGT = 3'd5;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [15:0] rep_bitrate(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [REP_W-1:0] r);
    logic [127:0] packed_br;
    packed_br = {hi, lo};
    return packed_br[r*16 +: 16];
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] q);
    return (q[63:32] != 32'd0) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // throughput sample: saturate and never report zero
  function automatic logic [31:0] rate_sat(input logic [63:0] q);
    logic [31:0] s;
    s = sat32(q);
    return (s == 32'd0) ? 32'd1 : s;
  endfunction

endpackage

@@ rtl/mpc_bitrate_selector_top.sv @@
// Top level: config registers, history, decision sequencer and result register.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  first_segment, bytes, transfer, fetch, buffer
//   out_     output     out_valid/out_stall  next_rep, bandwidth_estimate_kbps
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// One word takes up to 18 divisions on the single divider, then scores every plan,
// reps^5 of them (32768 at 8 reps). A first-segment word skips both and goes straight
// to the output stage. in_stall is high from acceptance until the result moves into
// the output register; a stalled result holds there. Reset is synchronous and clears
// history and control at once.
module mpc_bitrate_selector_top import mbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_first_segment,
  input  logic [31:0]           in_bytes_received,
  input  logic [31:0]           in_transfer_time_us,
  input  logic [31:0]           in_fetch_time_us,
  input  logic [31:0]           in_buffer_level_us,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_next_rep,
  output logic [31:0]           out_bandwidth_estimate_kbps,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RATE    = 5'd1;
  localparam logic [4:0] S_RATE_W  = 5'd2;
  localparam logic [4:0] S_ERR     = 5'd3;
  localparam logic [4:0] S_ERR_W   = 5'd4;
  localparam logic [4:0] S_PUSH    = 5'd5;
  localparam logic [4:0] S_SAMP    = 5'd6;
  localparam logic [4:0] S_SAMP_W  = 5'd7;
  localparam logic [4:0] S_CHK     = 5'd8;
  localparam logic [4:0] S_SUM     = 5'd9;
  localparam logic [4:0] S_SUM_W   = 5'd10;
  localparam logic [4:0] S_HMEAN   = 5'd11;
  localparam logic [4:0] S_HMEAN_W = 5'd12;
  localparam logic [4:0] S_FEST    = 5'd13;
  localparam logic [4:0] S_FEST_W  = 5'd14;
  localparam logic [4:0] S_DT      = 5'd15;
  localparam logic [4:0] S_DT_W    = 5'd16;
  localparam logic [4:0] S_PINIT   = 5'd17;
  localparam logic [4:0] S_STEP    = 5'd18;
  localparam logic [4:0] S_RW1     = 5'd19;
  localparam logic [4:0] S_RW2     = 5'd20;
  localparam logic [4:0] S_DONE    = 5'd21;

  // configuration
  logic [3:0]  rep_count_r;
  logic [63:0] br_lo_r, br_hi_r;
  logic [31:0] seg_r;
  logic [15:0] rbw_r, smw_r;

  // control and history
  logic [4:0]        state_r, state_nxt;
  logic [31:0]       thr_r [HIST_DEPTH];
  logic [31:0]       thr_nxt [HIST_DEPTH];
  logic [31:0]       err_r [HIST_DEPTH];
  logic [31:0]       err_nxt [HIST_DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [REP_W-1:0]  last_rep_r, last_rep_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working data
  logic [31:0]              bytes_r, bytes_nxt;
  logic [31:0]              xfer_r, xfer_nxt;
  logic [31:0]              fetch_r, fetch_nxt;
  logic [31:0]              bufl_r, bufl_nxt;
  logic [31:0]              b_r, b_nxt;
  logic [31:0]              newerr_r, newerr_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [31:0]              h_r, h_nxt;
  logic [31:0]              f_r, f_nxt;
  logic [DT_W-1:0]          dt_r [MAX_REPS];
  logic [DT_W-1:0]          dt_nxt [MAX_REPS];
  logic [REP_W-1:0]         digit_r [HORIZON];
  logic [REP_W-1:0]         digit_nxt [HORIZON];
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [REP_W-1:0]         lastq_r, lastq_nxt;
  logic signed [ACC_W-1:0]  buf_r, buf_nxt;
  logic [REBUF_W-1:0]       rebuf_r, rebuf_nxt;
  logic [BSUM_W-1:0]        bsum_r, bsum_nxt;
  logic [BSUM_W-1:0]        diffs_r, diffs_nxt;
  logic [36:0]              p1_r, p1_nxt;
  logic [55:0]              p2_r, p2_nxt;
  logic [34:0]              p3_r, p3_nxt;
  logic signed [63:0]       best_r, best_nxt;
  logic [REP_W-1:0]         choice_r, choice_nxt;
  logic [REP_W-1:0]         res_rep_r, res_rep_nxt;
  logic [31:0]              res_bw_r, res_bw_nxt;
  logic [REP_W-1:0]         out_rep_r, out_rep_nxt;
  logic [31:0]              out_bw_r, out_bw_nxt;

  // combinational helpers
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [31:0]             maxerr;
  logic [REP_W-1:0]        reps_m1;
  logic [15:0]             br_s, pb_s, bdiff_s;
  logic [DT_W-1:0]         dt_s;
  logic signed [ACC_W-1:0] dt_ext, add_s;
  logic [ACC_W-1:0]        rsum_s;
  logic [REP_W-1:0]        dig_inc [HORIZON];
  logic                    carry;
  logic [44:0]             p3k;
  logic signed [63:0]      reward;
  logic [31:0]             dq;
  logic [44:0]             bytes8k;
  logic                    out_free;
  logic                    accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    maxerr = err_r[0];
    for (int i = 1; i < HIST_DEPTH; i++) begin
      if (err_r[i] > maxerr) maxerr = err_r[i];
    end
  end

  always_comb begin
    if (rep_count_r == 4'd0) begin
      reps_m1 = '0;
    end else if (rep_count_r > 4'(MAX_REPS)) begin
      reps_m1 = REP_W'(MAX_REPS - 1);
    end else begin
      reps_m1 = REP_W'(rep_count_r - 4'd1);
    end
  end

  // next plan in lexicographic order; carry out means the last plan was scored
  always_comb begin
    carry = 1'b1;
    for (int k = HORIZON - 1; k >= 0; k--) begin
      dig_inc[k] = digit_r[k];
      if (carry) begin
        if (digit_r[k] == reps_m1) begin
          dig_inc[k] = '0;
        end else begin
          dig_inc[k] = digit_r[k] + 1'b1;
          carry      = 1'b0;
        end
      end
    end
  end

  // one planning step per cycle while in the step state
  always_comb begin
    br_s    = rep_bitrate(br_lo_r, br_hi_r, digit_r[step_r]);
    pb_s    = rep_bitrate(br_lo_r, br_hi_r, lastq_r);
    bdiff_s = (br_s > pb_s) ? (br_s - pb_s) : (pb_s - br_s);
    dt_s    = dt_r[digit_r[step_r]];
    dt_ext  = $signed({2'b00, dt_s});
    add_s   = dt_ext - buf_r;
    rsum_s  = {{(ACC_W-REBUF_W){1'b0}}, rebuf_r} + add_s[ACC_W-1:0];
    p3k     = p3_r * 10'd1000;
    reward  = $signed({27'd0, p1_r}) - $signed({8'd0, p2_r}) - $signed({19'd0, p3k});
    dq      = (prev_r > b_r) ? (prev_r - b_r) : (b_r - prev_r);
    bytes8k = bytes_r * 13'd8000;
  end

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    prev_nxt      = prev_r;
    last_rep_nxt  = last_rep_r;
    out_valid_nxt = out_valid_r && out_stall;
    bytes_nxt     = bytes_r;
    xfer_nxt      = xfer_r;
    fetch_nxt     = fetch_r;
    bufl_nxt      = bufl_r;
    b_nxt         = b_r;
    newerr_nxt    = newerr_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    h_nxt         = h_r;
    f_nxt         = f_r;
    dt_nxt        = dt_r;
    digit_nxt     = digit_r;
    step_nxt      = step_r;
    lastq_nxt     = lastq_r;
    buf_nxt       = buf_r;
    rebuf_nxt     = rebuf_r;
    bsum_nxt      = bsum_r;
    diffs_nxt     = diffs_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    best_nxt      = best_r;
    choice_nxt    = choice_r;
    res_rep_nxt   = res_rep_r;
    res_bw_nxt    = res_bw_r;
    out_rep_nxt   = out_rep_r;
    out_bw_nxt    = out_bw_r;
    div_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bytes_nxt = in_bytes_received;
          xfer_nxt  = in_transfer_time_us;
          fetch_nxt = in_fetch_time_us;
          bufl_nxt  = in_buffer_level_us;
          if (in_first_segment) begin
            last_rep_nxt = '0;
            res_rep_nxt  = '0;
            res_bw_nxt   = '0;
            state_nxt    = S_DONE;
          end else if (valid_r && (in_bytes_received != 32'd0)) begin
            state_nxt = S_RATE;
          end else begin
            // no sample against a live estimate counts as a maximal error
            newerr_nxt = valid_r ? 32'hFFFF_FFFF : 32'd0;
            state_nxt  = S_PUSH;
          end
        end
      end
      S_RATE: begin
        div_req.start = 1'b1;
        div_req.num   = {19'd0, bytes8k};
        div_req.den   = {32'd0, (xfer_r == 32'd0) ? 32'd1 : xfer_r};
        state_nxt     = S_RATE_W;
      end
      S_RATE_W: begin
        if (div_rsp.done) begin
          b_nxt     = rate_sat(div_rsp.quo);
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, dq, 16'd0};
        div_req.den   = {32'd0, b_r};
        state_nxt     = S_ERR_W;
      end
      S_ERR_W: begin
        if (div_rsp.done) begin
          newerr_nxt = sat32(div_rsp.quo);
          state_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        err_nxt[0] = newerr_r;
        for (int i = 1; i < HIST_DEPTH; i++) err_nxt[i] = err_r[i-1];
        state_nxt = (bytes_r != 32'd0) ? S_SAMP : S_CHK;
      end
      S_SAMP: begin
        div_req.start = 1'b1;
        div_req.num   = {19'd0, bytes8k};
        div_req.den   = {32'd0, (fetch_r == 32'd0) ? 32'd1 : fetch_r};
        state_nxt     = S_SAMP_W;
      end
      S_SAMP_W: begin
        if (div_rsp.done) begin
          thr_nxt[0] = rate_sat(div_rsp.quo);
          for (int i = 1; i < HIST_DEPTH; i++) thr_nxt[i] = thr_r[i-1];
          if (cnt_r < CNT_W'(HIST_DEPTH)) cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cnt_r == '0) begin
          valid_nxt   = 1'b0;
          prev_nxt    = '0;
          res_rep_nxt = last_rep_r;
          res_bw_nxt  = '0;
          state_nxt   = S_DONE;
        end else begin
          idx_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        div_req.start = 1'b1;
        div_req.num   = 64'd1 << 48;
        div_req.den   = {32'd0, (thr_r[idx_r] == 32'd0) ? 32'd1 : thr_r[idx_r]};
        state_nxt     = S_SUM_W;
      end
      S_SUM_W: begin
        if (div_rsp.done) begin
          sum_nxt = sum_r + div_rsp.quo[SUM_W-1:0];
          if (idx_r == CNT_W'(cnt_r - 1'b1)) begin
            state_nxt = S_HMEAN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SUM;
          end
        end
      end
      S_HMEAN: begin
        div_req.start = 1'b1;
        div_req.num   = {13'd0, cnt_r, 48'd0};
        div_req.den   = {13'd0, sum_r};
        state_nxt     = S_HMEAN_W;
      end
      S_HMEAN_W: begin
        if (div_rsp.done) begin
          h_nxt     = sat32(div_rsp.quo);
          state_nxt = S_FEST;
        end
      end
      S_FEST: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, h_r, 16'd0};
        div_req.den   = {31'd0, {1'b0, maxerr} + 33'd65536};
        state_nxt     = S_FEST_W;
      end
      S_FEST_W: begin
        if (div_rsp.done) begin
          f_nxt     = div_rsp.quo[31:0];
          prev_nxt  = h_r;
          valid_nxt = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_DT;
        end
      end
      S_DT: begin
        // download time of each rep at the discounted rate; zero rate plans as 1
        div_req.start = 1'b1;
        div_req.num   = {16'd0, DT_W'(rep_bitrate(br_lo_r, br_hi_r, idx_r)) * DT_W'(seg_r)};
        div_req.den   = {32'd0, (f_r == 32'd0) ? 32'd1 : f_r};
        state_nxt     = S_DT_W;
      end
      S_DT_W: begin
        if (div_rsp.done) begin
          dt_nxt[idx_r] = div_rsp.quo[DT_W-1:0];
          if (idx_r == 3'(MAX_REPS - 1)) begin
            state_nxt = S_PINIT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DT;
          end
        end
      end
      S_PINIT: begin
        for (int k = 0; k < HORIZON; k++) digit_nxt[k] = '0;
        best_nxt   = BEST_INIT;
        choice_nxt = last_rep_r;
        step_nxt   = '0;
        buf_nxt    = $signed({18'd0, bufl_r}) - $signed({18'd0, seg_r});
        rebuf_nxt  = '0;
        bsum_nxt   = '0;
        diffs_nxt  = '0;
        lastq_nxt  = last_rep_r;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (buf_r < dt_ext) begin
          rebuf_nxt = (rsum_s > {{(ACC_W-REBUF_W){1'b0}}, REBUF_CAP}) ?
                      REBUF_CAP : rsum_s[REBUF_W-1:0];
          buf_nxt   = $signed({18'd0, seg_r});
        end else begin
          buf_nxt = buf_r - dt_ext + $signed({18'd0, seg_r});
        end
        bsum_nxt  = bsum_r + {3'd0, br_s};
        diffs_nxt = diffs_r + {3'd0, bdiff_s};
        lastq_nxt = digit_r[step_r];
        if (step_r == STEP_W'(HORIZON - 1)) begin
          step_nxt  = '0;
          state_nxt = S_RW1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_RW1: begin
        p1_nxt    = bsum_r * 18'd256000;
        p2_nxt    = rbw_r * rebuf_r;
        p3_nxt    = smw_r * diffs_r;
        state_nxt = S_RW2;
      end
      S_RW2: begin
        // ties go to the later plan
        if (reward >= best_r) begin
          best_nxt   = reward;
          choice_nxt = digit_r[0];
        end
        digit_nxt = dig_inc;
        if (carry) begin
          last_rep_nxt = choice_nxt;
          res_rep_nxt  = choice_nxt;
          res_bw_nxt   = f_r;
          state_nxt    = S_DONE;
        end else begin
          buf_nxt   = $signed({18'd0, bufl_r}) - $signed({18'd0, seg_r});
          rebuf_nxt = '0;
          bsum_nxt  = '0;
          diffs_nxt = '0;
          lastq_nxt = last_rep_r;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rep_nxt   = res_rep_r;
          out_bw_nxt    = res_bw_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= 1'b0;
      prev_r      <= '0;
      last_rep_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        thr_r[i] <= '0;
        err_r[i] <= '0;
      end
      rep_count_r <= 4'd1;
      br_lo_r     <= '0;
      br_hi_r     <= '0;
      seg_r       <= 32'd2000000;
      rbw_r       <= 16'd1101;
      smw_r       <= 16'd256;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      prev_r      <= prev_nxt;
      last_rep_r  <= last_rep_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      err_r       <= err_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_REP_COUNT:  rep_count_r <= cfg_data[3:0];
          CFG_BR_LOW:     br_lo_r     <= cfg_data;
          CFG_BR_HIGH:    br_hi_r     <= cfg_data;
          CFG_SEG_DUR:    seg_r       <= cfg_data[31:0];
          CFG_REBUF_WGT:  rbw_r       <= cfg_data[15:0];
          CFG_SMOOTH_WGT: smw_r       <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes_r   <= bytes_nxt;
    xfer_r    <= xfer_nxt;
    fetch_r   <= fetch_nxt;
    bufl_r    <= bufl_nxt;
    b_r       <= b_nxt;
    newerr_r  <= newerr_nxt;
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    h_r       <= h_nxt;
    f_r       <= f_nxt;
    dt_r      <= dt_nxt;
    digit_r   <= digit_nxt;
    step_r    <= step_nxt;
    lastq_r   <= lastq_nxt;
    buf_r     <= buf_nxt;
    rebuf_r   <= rebuf_nxt;
    bsum_r    <= bsum_nxt;
    diffs_r   <= diffs_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    p3_r      <= p3_nxt;
    best_r    <= best_nxt;
    choice_r  <= choice_nxt;
    res_rep_r <= res_rep_nxt;
    res_bw_r  <= res_bw_nxt;
    out_rep_r <= out_rep_nxt;
    out_bw_r  <= out_bw_nxt;
  end

  mbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid                   = out_valid_r;
  assign out_next_rep                = out_rep_r;
  assign out_bandwidth_estimate_kbps = out_bw_r;

endmodule

@@ rtl/mbs_div.sv @@
// Shared iterative 64/64 restoring divider, one quotient bit per cycle.
module mbs_div import mbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, quo_r[63]};
    diff     = sh - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ rtl/mbs_checker.sv @@
// Port-level checker for the bitrate selector, bound to the top level.
`include "assert_macros.svh"

module mbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_next_rep,
  input logic [31:0] out_bandwidth_estimate_kbps
);

  // one word in flight: block is busy right after taking a word
  `MBS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // a fresh result only appears after the block was busy in the previous cycle
  `MBS_ASSERT_IMPL(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

  `MBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_next_rep) && $stable(out_bandwidth_estimate_kbps))

  `MBS_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind mpc_bitrate_selector_top mbs_checker u_mbs_checker (.*);
